// ----- design/tlnf_pkg.sv -----
// Shared types and constants for the text line numbering filter.
`default_nettype none

package tlnf_pkg;

  localparam int unsigned CountDigits = 6;
  localparam int unsigned CountW      = 4 * CountDigits;
  localparam int unsigned NumLen      = CountDigits + 1;
  localparam int unsigned MaxResults  = CountDigits + 4;
  localparam int unsigned StepW       = $clog2(MaxResults);
  localparam int unsigned NumIdxW     = $clog2(NumLen);
  localparam int unsigned AddrW       = 5;

  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharQuest  = 8'h3F;
  localparam logic [7:0] CharI      = 8'h49;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharDel    = 8'h7F;
  localparam logic [7:0] CharCtlEnd = 8'h20;
  localparam logic [7:0] CaretOfs   = 8'h40;

  typedef enum logic [2:0] {
    RegNumberAll      = 3'd0,
    RegNumberNonblank = 3'd1,
    RegSqueeze        = 3'd2,
    RegMarkEnds       = 3'd3,
    RegShowTabs       = 3'd4,
    RegShowNonprint   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze;
    logic mark_ends;
    logic show_tabs;
    logic show_nonprint;
  } cfg_t;

  typedef struct packed {
    logic       drop;
    logic       number;
    logic       last;
    logic [7:0] data;
    logic [1:0] blank_run;
  } fmt_t;

endpackage

`default_nettype wire

// ----- design/tlnf_regs.sv -----
// APB configuration registers of the line numbering filter.
`default_nettype none

module tlnf_regs import tlnf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  cfg_reg_e reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_reg_e'(paddr[AddrW-1:2]);
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegNumberAll:      cfg_d.number_all      = pwdata[0];
        RegNumberNonblank: cfg_d.number_nonblank = pwdata[0];
        RegSqueeze:        cfg_d.squeeze         = pwdata[0];
        RegMarkEnds:       cfg_d.mark_ends       = pwdata[0];
        RegShowTabs:       cfg_d.show_tabs       = pwdata[0];
        RegShowNonprint:   cfg_d.show_nonprint   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegNumberAll:      prdata[0] = cfg_q.number_all;
      RegNumberNonblank: prdata[0] = cfg_q.number_nonblank;
      RegSqueeze:        prdata[0] = cfg_q.squeeze;
      RegMarkEnds:       prdata[0] = cfg_q.mark_ends;
      RegShowTabs:       prdata[0] = cfg_q.show_tabs;
      RegShowNonprint:   prdata[0] = cfg_q.show_nonprint;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/tlnf_count.sv -----
// Saturating BCD line counter.
`default_nettype none

module tlnf_count import tlnf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              bump_i,
  output logic      [CountW-1:0] count_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              all_nines;
  logic              carry;

  always_comb begin
    all_nines = 1'b1;
    for (int i = 0; i < CountDigits; i++) begin
      if (count_q[4*i +: 4] != 4'd9) all_nines = 1'b0;
    end
    count_d = count_q;
    carry   = bump_i & ~all_nines;
    for (int i = 0; i < CountDigits; i++) begin
      if (carry) begin
        if (count_q[4*i +: 4] >= 4'd9) begin
          count_d[4*i +: 4] = 4'd0;
        end else begin
          count_d[4*i +: 4] = count_q[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ----- design/tlnf_format.sv -----
// Line start decisions and output byte selection for one held byte.
`default_nettype none

module tlnf_format import tlnf_pkg::*; (
  input  wire cfg_t              cfg_i,
  input  wire logic [7:0]        data_i,
  input  wire logic              file_start_i,
  input  wire logic              at_line_start_i,
  input  wire logic [1:0]        blank_run_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire logic [StepW-1:0]  step_i,
  output fmt_t                   fmt_o
);

  logic             at_start;
  logic             blank;
  logic [1:0]       br_base;
  logic [1:0]       br_next;
  logic             drop;
  logic             number;
  logic             lead;
  logic [3:0]       dig;
  logic [7:0]       num_chars [NumLen];
  logic [7:0]       tail [4];
  logic [2:0]       tail_cnt;
  logic [7:0]       shown;
  logic [StepW-1:0] num_len;
  logic [StepW-1:0] total;
  logic [StepW-1:0] tail_idx;
  logic [7:0]       sel_byte;

  always_comb begin
    at_start = at_line_start_i | file_start_i;
    blank    = (data_i == CharNl);
    br_base  = file_start_i ? 2'd0 : blank_run_i;
    br_next  = br_base;
    if (at_start) begin
      if (blank) br_next = (br_base == 2'd2) ? 2'd2 : br_base + 2'd1;
      else       br_next = 2'd0;
    end
    drop   = at_start & cfg_i.squeeze & br_next[1];
    number = at_start & ~drop &
             (cfg_i.number_nonblank ? ~blank : cfg_i.number_all);
  end

  // right-justified digits, leading zeros blanked
  always_comb begin
    lead = 1'b1;
    dig  = '0;
    for (int s = 0; s < CountDigits; s++) begin
      dig = count_i[4*(CountDigits-1-s) +: 4];
      if (dig > 4'd9) dig = 4'd9;
      if (dig != 4'd0 || s == CountDigits - 1) lead = 1'b0;
      num_chars[s] = lead ? CharSpace : CharZero + {4'd0, dig};
    end
    num_chars[CountDigits] = CharTab;
  end

  always_comb begin
    for (int t = 0; t < 4; t++) tail[t] = '0;
    tail_cnt = '0;
    shown    = data_i;
    if (cfg_i.mark_ends && data_i == CharNl) begin
      tail[tail_cnt[1:0]] = CharDollar;
      tail_cnt = tail_cnt + 3'd1;
    end
    if (cfg_i.show_nonprint) begin
      if ((data_i < CharCtlEnd && data_i != CharTab && data_i != CharNl) || data_i[7]) begin
        tail[tail_cnt[1:0]] = CharCaret;
        tail_cnt = tail_cnt + 3'd1;
        shown    = data_i + CaretOfs;
      end else if (data_i == CharDel) begin
        tail[tail_cnt[1:0]] = CharCaret;
        tail_cnt = tail_cnt + 3'd1;
        shown    = CharQuest;
      end
    end
    if (cfg_i.show_tabs && shown == CharTab) begin
      tail[tail_cnt[1:0]]        = CharCaret;
      tail[tail_cnt[1:0] + 2'd1] = CharI;
      tail_cnt = tail_cnt + 3'd2;
    end else begin
      tail[tail_cnt[1:0]] = shown;
      tail_cnt = tail_cnt + 3'd1;
    end
  end

  always_comb begin
    num_len  = number ? StepW'(NumLen) : '0;
    total    = num_len + StepW'(tail_cnt);
    tail_idx = step_i - num_len;
    if (step_i < num_len) sel_byte = num_chars[step_i[NumIdxW-1:0]];
    else                  sel_byte = tail[tail_idx[1:0]];
  end

  assign fmt_o.drop      = drop;
  assign fmt_o.number    = number;
  assign fmt_o.last      = (step_i == total - StepW'(1));
  assign fmt_o.data      = sel_byte;
  assign fmt_o.blank_run = br_next;

endmodule

`default_nettype wire

// ----- design/text_line_numbering_filter_core.sv -----
// Top level of the text line numbering and display filter.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_byte_i, file_start_i
//   out      output     out_valid_o / out_stall_i  out_byte_o, last_of_run_o
//   cfg      input      APB psel/penable/pready    paddr, pwdata, prdata
//
// One output byte per cycle while the output is not stalled; a byte that expands to k results
// (up to 10 with a number prefix of 7) holds the input until its last result is emitted.
// A squeezed blank line gives no transaction on the output; all other results are registered.
// Reset clears the options, the line state and sets the line number to 1; no clearing pass.
// A stalled output holds its register; the input stalls only while the held byte is unfinished.
`default_nettype none

module text_line_numbering_filter_core import tlnf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             file_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [7:0]       out_byte_o,
  output logic                  last_of_run_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  cfg_t              cfg;
  fmt_t              fmt;
  logic [CountW-1:0] line_count;

  logic             item_vld_q;
  logic [7:0]       item_byte_q;
  logic             item_fs_q;
  logic [StepW-1:0] step_q, step_d;
  logic             at_line_start_q, at_line_start_d;
  logic [1:0]       blank_run_q, blank_run_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic out_free;
  logic emit;
  logic item_done;
  logic in_take;
  logic bump;

  tlnf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlnf_format u_format (
    .cfg_i           (cfg),
    .data_i          (item_byte_q),
    .file_start_i    (item_fs_q),
    .at_line_start_i (at_line_start_q),
    .blank_run_i     (blank_run_q),
    .count_i         (line_count),
    .step_i          (step_q),
    .fmt_o           (fmt)
  );

  tlnf_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bump_i  (bump),
    .count_o (line_count)
  );

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign emit       = item_vld_q & ~fmt.drop & out_free;
  assign item_done  = item_vld_q & (fmt.drop | (out_free & fmt.last));
  assign in_stall_o = item_vld_q & ~item_done;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign bump       = item_done & fmt.number;

  always_comb begin
    step_d          = step_q;
    at_line_start_d = at_line_start_q;
    blank_run_d     = blank_run_q;
    if (emit) step_d = fmt.last ? '0 : step_q + StepW'(1);
    if (item_done) begin
      blank_run_d     = fmt.blank_run;
      at_line_start_d = fmt.drop | (item_byte_q == CharNl);
    end
    out_vld_d = out_free ? emit : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q      <= 1'b0;
      step_q          <= '0;
      at_line_start_q <= 1'b1;
      blank_run_q     <= 2'd0;
      out_vld_q       <= 1'b0;
    end else begin
      if (in_take) item_vld_q <= 1'b1;
      else if (item_done) item_vld_q <= 1'b0;
      step_q          <= step_d;
      at_line_start_q <= at_line_start_d;
      blank_run_q     <= blank_run_d;
      out_vld_q       <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_byte_q <= in_byte_i;
      item_fs_q   <= file_start_i;
    end
    if (emit) begin
      out_byte_q <= fmt.data;
      out_last_q <= fmt.last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

`ifndef NO_ASSERTIONS
  a_step_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> item_vld_q)
    else $error("step counter running without a held byte");

  a_done_clears_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_done |=> step_q == '0)
    else $error("step counter not cleared after finished byte");

  a_count_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_done |=> $stable(line_count))
    else $error("line number moved without a finished byte");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q)
    else $error("input stalled with empty item register");

  a_drop_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && fmt.drop |-> step_q == '0 && !emit)
    else $error("squeezed line produced output");
`endif

endmodule

`default_nettype wire
